FILE: rtl/assert_macros.svh
// assertion macros used by the order book core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define OBSI_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define OBSI_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/obsi_pkg.sv
// types and constants of the sorted order book
`default_nettype none

package obsi_pkg;

	localparam int PRICE_W  = 32;
	localparam int TIME_W   = 32;
	localparam int TAG_W    = 32;
	localparam int RIDX_W   = 6;
	localparam int STATUS_W = 2;
	localparam int POS_W    = 6;
	localparam int COUNT_W  = 7;
	localparam int IN_DATA_W  = 104;
	localparam int OUT_DATA_W = 112;
	localparam int ENTRY_W  = PRICE_W + TIME_W + TAG_W;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_READ   = 1'b1;

	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

	localparam logic SIDE_BUY  = 1'b0;
	localparam logic SIDE_SELL = 1'b1;

	localparam logic REG_BOOK_SIDE = 1'b0;

	typedef struct packed {
		logic [TAG_W-1:0]   tag;
		logic [TIME_W-1:0]  ptime;
		logic [PRICE_W-1:0] price;
	} obsi_entry_t;

	typedef struct packed {
		logic        cmp_en;
		logic        shift_en;
		logic        side;
		obsi_entry_t new_entry;
	} obsi_cell_ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP,
		ST_SUM,
		ST_WRITE,
		ST_DONE
	} obsi_state_t;

endpackage

`default_nettype wire

FILE: rtl/obsi_cell.sv
// one slot of the sorted table: holds an entry, ranks it, shifts it on insert
`default_nettype none

module obsi_cell
	import obsi_pkg::*;
#(
	parameter int IDX = 0,
	parameter int CW  = 7
) (
	input  wire logic              clk,
	input  wire obsi_cell_ctrl_t   ctrl,
	input  wire logic [CW-1:0]     at,
	input  wire logic [CW-1:0]     count,
	input  wire logic [RIDX_W-1:0] read_index,
	input  wire obsi_entry_t       prev,
	output obsi_entry_t            entry,
	output logic                   ahead,
	output logic                   hit
);

	localparam int RW = (CW > RIDX_W) ? CW : RIDX_W;
	localparam logic [CW-1:0] IdxC = CW'(IDX);
	localparam logic [RW-1:0] IdxR = RW'(IDX);

	obsi_entry_t entry_q;
	logic        ahead_q;
	logic        hit_q;
	logic        occupied;
	logic        rank_ahead;

	assign occupied = (IdxC < count);

	always_comb begin
		if (entry_q.price != ctrl.new_entry.price) begin
			if (ctrl.side == SIDE_SELL) begin
				rank_ahead = (entry_q.price < ctrl.new_entry.price);
			end else begin
				rank_ahead = (entry_q.price > ctrl.new_entry.price);
			end
		end else begin
			rank_ahead = (entry_q.ptime > ctrl.new_entry.ptime);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.cmp_en) begin
			ahead_q <= occupied && rank_ahead;
			hit_q   <= (RW'(read_index) == IdxR);
		end
		if (ctrl.shift_en) begin
			if (IdxC == at) begin
				entry_q <= ctrl.new_entry;
			end else if ((IdxC > at) && (IdxC <= count)) begin
				entry_q <= prev;
			end
		end
	end

	assign entry = entry_q;
	assign ahead = ahead_q;
	assign hit   = hit_q;

endmodule

`default_nettype wire

FILE: rtl/obsi_popcnt.sv
// registered adder tree counting the cells that rank ahead
`default_nettype none

module obsi_popcnt
	import obsi_pkg::*;
#(
	parameter int N  = 64,
	parameter int CW = 7
) (
	input  wire logic          clk,
	input  wire logic [N-1:0]  bits,
	output logic [CW-1:0]      sum
);

	localparam int L = $clog2(N);
	localparam int P = 1 << L;

	logic [P-1:0]  leaf;
	logic [CW-1:0] node_q [1:P-1];

	assign leaf = P'(bits);

	always_ff @(posedge clk) begin
		for (int n = 1; n < P; n++) begin
			if (2 * n >= P) begin
				node_q[n] <= CW'(leaf[2*n-P]) + CW'(leaf[2*n+1-P]);
			end else begin
				node_q[n] <= node_q[2*n] + node_q[2*n+1];
			end
		end
	end

	assign sum = node_q[1];

endmodule

`default_nettype wire

FILE: rtl/order_book_sorted_insert_core.sv
// top level of the sorted order book: cell row, rank counter, control and ports
//
// channel   dir  handshake              payload
// s_axis    in   s_tvalid / s_tready     s_tuser action, s_tdata order or index
// m_axis    out  m_tvalid / m_tready     m_tdata result
// apb       in   psel penable pwrite     book_side at address 0
//
// an insert runs a rank compare in every cell, then the
// registered adder tree that turns rank bits into a position, a shift step
// and a result step; a read or a rejected insert goes from compare to result
// one item is worked at a time; the result register frees the input side
// reset clears the count, the side and the handshake state, not the slots
// a stalled result holds the next item in its last cycle until taken
`default_nettype none

module order_book_sorted_insert_core
	import obsi_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,  // price, priority_time, order_tag, read_index, pad
	input  wire logic                  s_tuser,  // action
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,  // status, position, entry_count, entry_price,
	                                             // entry_time, entry_tag, pad
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [2:0]            paddr,
	input  wire logic [31:0]           pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	`include "assert_macros.svh"

	localparam int CW  = $clog2(DEPTH + 1);
	localparam int L   = $clog2(DEPTH);
	localparam int WCW = $clog2(L + 1);
	localparam int RW  = (CW > RIDX_W) ? CW : RIDX_W;
	localparam logic [CW-1:0] DepthC = CW'(DEPTH);

	obsi_state_t       state_q, state_d;
	logic              side_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     at_q;
	logic [WCW-1:0]    wait_q;
	logic              act_q;
	obsi_entry_t       new_q;
	logic [RIDX_W-1:0] ridx_q;

	obsi_cell_ctrl_t   cell_ctrl;
	obsi_entry_t       cell_entry [DEPTH];
	logic [DEPTH-1:0]  cell_ahead;
	logic [DEPTH-1:0]  cell_hit;
	logic [CW-1:0]     rank_sum;
	logic [ENTRY_W-1:0] rd_bits;

	logic              in_acc;
	logic              out_load;
	logic              cfg_wr;
	logic              is_full;
	logic              out_range;

	logic [STATUS_W-1:0] res_status;
	logic [POS_W-1:0]    res_pos;
	obsi_entry_t         res_entry;
	logic [OUT_DATA_W-1:0] out_q;
	logic                out_valid_q;

	// marks that the item in flight was placed, so a table filled by it is not full
	logic inserted_q;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= SIDE_BUY;
		end else if (cfg_wr && (paddr[2] == REG_BOOK_SIDE)) begin
			side_q <= pwdata[0];
		end
	end

	assign prdata = (paddr[2] == REG_BOOK_SIDE) ? {31'd0, side_q} : 32'd0;

	// cell row
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		obsi_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk        (clk),
			.ctrl       (cell_ctrl),
			.at         (rank_sum),
			.count      (count_q),
			.read_index (ridx_q),
			.prev       ((i == 0) ? new_q : cell_entry[(i == 0) ? 0 : i-1]),
			.entry      (cell_entry[i]),
			.ahead      (cell_ahead[i]),
			.hit        (cell_hit[i])
		);
	end

	obsi_popcnt #(
		.N  (DEPTH),
		.CW (CW)
	) u_popcnt (
		.clk  (clk),
		.bits (cell_ahead),
		.sum  (rank_sum)
	);

	always_comb begin
		rd_bits = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (cell_hit[i]) begin
				rd_bits = rd_bits | cell_entry[i];
			end
		end
	end

	// control
	assign in_acc    = s_tvalid && s_tready;
	assign is_full   = (count_q == DepthC);
	assign out_range = (RW'(ridx_q) >= RW'(count_q));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				if ((act_q == ACT_READ) || is_full) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_SUM;
				end
			end
			ST_SUM: begin
				if (wait_q == WCW'(L - 1)) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: state_d = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready            = 1'b0;
		cell_ctrl.cmp_en    = 1'b0;
		cell_ctrl.shift_en  = 1'b0;
		cell_ctrl.side      = side_q;
		cell_ctrl.new_entry = new_q;
		out_load            = 1'b0;
		unique case (state_q)
			ST_IDLE:  s_tready = 1'b1;
			ST_CMP:   cell_ctrl.cmp_en = 1'b1;
			ST_SUM:   ;
			ST_WRITE: cell_ctrl.shift_en = 1'b1;
			ST_DONE:  out_load = !out_valid_q || m_tready;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			wait_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SUM) begin
				wait_q <= wait_q + WCW'(1);
			end else begin
				wait_q <= '0;
			end
			if (state_q == ST_WRITE) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_q       <= s_tuser;
			new_q.price <= s_tdata[31:0];
			new_q.ptime <= s_tdata[63:32];
			new_q.tag   <= s_tdata[95:64];
			ridx_q      <= s_tdata[101:96];
		end
		if (state_q == ST_CMP) begin
			at_q <= '0;
		end else if (state_q == ST_WRITE) begin
			at_q <= rank_sum;
		end
	end

	// the cells shift at rank_sum in the write cycle; at_q keeps it for the result
	always_comb begin
		res_status = STAT_OK;
		res_pos    = '0;
		res_entry  = '0;
		if (act_q == ACT_READ) begin
			res_pos = ridx_q;
			if (out_range) begin
				res_status = STAT_RANGE;
			end else begin
				res_entry = rd_bits;
			end
		end else if (is_full && (at_q == '0) && !cell_ctrl.shift_en && wait_q == '0
				&& state_q == ST_DONE && !inserted_q) begin
			res_status = STAT_FULL;
		end else begin
			res_pos = POS_W'(at_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inserted_q <= 1'b0;
		end else if (state_q == ST_CMP) begin
			inserted_q <= 1'b0;
		end else if (state_q == ST_WRITE) begin
			inserted_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= {1'b0, res_entry.tag, res_entry.ptime, res_entry.price,
				COUNT_W'(count_q), res_pos, res_status};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	`OBSI_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= DepthC,
		"held count beyond table depth")
	`OBSI_ASSERT_IMP(a_shift_room, clk, arst_n, state_q == ST_WRITE, count_q < DepthC,
		"shift into a full table")
	`OBSI_ASSERT_IMP(a_count_step, clk, arst_n, count_q != $past(count_q),
		$past(state_q) == ST_WRITE, "count changed outside the shift cycle")
	`OBSI_ASSERT_IMP(a_out_source, clk, arst_n, $rose(m_tvalid),
		$past(state_q) == ST_DONE, "result raised outside the result cycle")

endmodule

`default_nettype wire
